>>> design/fmia_pkg.sv
`default_nettype none
package fmia_pkg;

    localparam int VAL_W      = 48;
    localparam int THR_W      = 47;
    localparam int IDX_W      = 8;
    localparam int NBASIS_DEF = 64;
    localparam int S_DATA_W   = 144;
    localparam int M_DATA_W   = 48;
    localparam int PP_W       = 24;
    localparam int PROD_W     = 96;

    typedef enum logic [1:0] {
        REQ_LOAD_D = 2'd0,
        REQ_LOAD_F = 2'd1,
        REQ_INT    = 2'd2,
        REQ_READ   = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        IC_ALL  = 3'd0,
        IC_MMPP = 3'd1,
        IC_MNMN = 3'd2,
        IC_MM   = 3'd3,
        IC_PP   = 3'd4,
        IC_GEN  = 3'd5
    } icase_t;

    typedef enum logic [1:0] {
        SEL_M = 2'd0,
        SEL_N = 2'd1,
        SEL_P = 2'd2,
        SEL_Q = 2'd3
    } sel_t;

    typedef struct packed {
        sel_t fr;
        sel_t fc;
        sel_t dr;
        sel_t dc;
        logic half;
        logic sub;
    } upd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_RD, ST_RDOUT, ST_CHECK, ST_FETCH,
        ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_RND, ST_ACC
    } state_t;

    typedef struct packed {
        logic       latch_in;
        logic       do_load;
        logic       rd_elem;
        logic       load_out;
        logic       chk;
        logic       fetch;
        logic       mul;
        logic [1:0] mul_idx;
        logic       rnd;
        logic       acc;
    } cmd_t;

    typedef struct packed {
        req_kind_t kind;
        logic      int_ok;
        logic      last_step;
        logic      out_busy;
    } stat_t;

    function automatic upd_t mk(sel_t fr, sel_t fc, sel_t dr, sel_t dc, logic h, logic s);
        upd_t u;
        u.fr = fr; u.fc = fc; u.dr = dr; u.dc = dc; u.half = h; u.sub = s;
        return u;
    endfunction

    function automatic logic [3:0] last_of(icase_t c);
        logic [3:0] r;
        unique case (c)
            IC_ALL:  r = 4'd0;
            IC_MMPP: r = 4'd3;
            IC_MNMN: r = 4'd5;
            IC_MM:   r = 4'd7;
            IC_PP:   r = 4'd7;
            default: r = 4'd15;
        endcase
        return r;
    endfunction

    function automatic upd_t upd_lookup(icase_t c, logic [3:0] st);
        upd_t u;
        u = mk(SEL_M, SEL_M, SEL_M, SEL_M, 1'b1, 1'b0);
        unique case (c)
            IC_ALL: u = mk(SEL_M, SEL_M, SEL_M, SEL_M, 1'b1, 1'b0);
            IC_MMPP: begin
                unique case (st[1:0])
                    2'd0: u = mk(SEL_M, SEL_M, SEL_P, SEL_P, 1'b0, 1'b0);
                    2'd1: u = mk(SEL_P, SEL_P, SEL_M, SEL_M, 1'b0, 1'b0);
                    2'd2: u = mk(SEL_M, SEL_P, SEL_M, SEL_P, 1'b1, 1'b1);
                    default: u = mk(SEL_P, SEL_M, SEL_P, SEL_M, 1'b1, 1'b1);
                endcase
            end
            IC_MNMN: begin
                unique case (st[2:0])
                    3'd0: u = mk(SEL_M, SEL_N, SEL_M, SEL_N, 1'b0, 1'b0);
                    3'd1: u = mk(SEL_M, SEL_N, SEL_N, SEL_M, 1'b1, 1'b0);
                    3'd2: u = mk(SEL_N, SEL_M, SEL_N, SEL_M, 1'b0, 1'b0);
                    3'd3: u = mk(SEL_N, SEL_M, SEL_M, SEL_N, 1'b1, 1'b0);
                    3'd4: u = mk(SEL_N, SEL_N, SEL_M, SEL_M, 1'b1, 1'b1);
                    default: u = mk(SEL_M, SEL_M, SEL_N, SEL_N, 1'b1, 1'b1);
                endcase
            end
            IC_MM: begin
                unique case (st[2:0])
                    3'd0: u = mk(SEL_M, SEL_M, SEL_P, SEL_Q, 1'b0, 1'b0);
                    3'd1: u = mk(SEL_M, SEL_M, SEL_Q, SEL_P, 1'b0, 1'b0);
                    3'd2: u = mk(SEL_P, SEL_Q, SEL_M, SEL_M, 1'b0, 1'b0);
                    3'd3: u = mk(SEL_Q, SEL_P, SEL_M, SEL_M, 1'b0, 1'b0);
                    3'd4: u = mk(SEL_M, SEL_P, SEL_M, SEL_Q, 1'b1, 1'b1);
                    3'd5: u = mk(SEL_P, SEL_M, SEL_Q, SEL_M, 1'b1, 1'b1);
                    3'd6: u = mk(SEL_M, SEL_Q, SEL_M, SEL_P, 1'b1, 1'b1);
                    default: u = mk(SEL_Q, SEL_M, SEL_P, SEL_M, 1'b1, 1'b1);
                endcase
            end
            IC_PP: begin
                unique case (st[2:0])
                    3'd0: u = mk(SEL_M, SEL_N, SEL_P, SEL_P, 1'b0, 1'b0);
                    3'd1: u = mk(SEL_N, SEL_M, SEL_P, SEL_P, 1'b0, 1'b0);
                    3'd2: u = mk(SEL_P, SEL_P, SEL_M, SEL_N, 1'b0, 1'b0);
                    3'd3: u = mk(SEL_P, SEL_P, SEL_N, SEL_M, 1'b0, 1'b0);
                    3'd4: u = mk(SEL_M, SEL_P, SEL_N, SEL_P, 1'b1, 1'b1);
                    3'd5: u = mk(SEL_P, SEL_M, SEL_P, SEL_N, 1'b1, 1'b1);
                    3'd6: u = mk(SEL_N, SEL_P, SEL_M, SEL_P, 1'b1, 1'b1);
                    default: u = mk(SEL_P, SEL_N, SEL_P, SEL_M, 1'b1, 1'b1);
                endcase
            end
            default: begin
                unique case (st)
                    4'd0:  u = mk(SEL_M, SEL_N, SEL_P, SEL_Q, 1'b0, 1'b0);
                    4'd1:  u = mk(SEL_N, SEL_M, SEL_P, SEL_Q, 1'b0, 1'b0);
                    4'd2:  u = mk(SEL_M, SEL_N, SEL_Q, SEL_P, 1'b0, 1'b0);
                    4'd3:  u = mk(SEL_N, SEL_M, SEL_Q, SEL_P, 1'b0, 1'b0);
                    4'd4:  u = mk(SEL_P, SEL_Q, SEL_M, SEL_N, 1'b0, 1'b0);
                    4'd5:  u = mk(SEL_P, SEL_Q, SEL_N, SEL_M, 1'b0, 1'b0);
                    4'd6:  u = mk(SEL_Q, SEL_P, SEL_M, SEL_N, 1'b0, 1'b0);
                    4'd7:  u = mk(SEL_Q, SEL_P, SEL_N, SEL_M, 1'b0, 1'b0);
                    4'd8:  u = mk(SEL_M, SEL_P, SEL_N, SEL_Q, 1'b1, 1'b1);
                    4'd9:  u = mk(SEL_P, SEL_M, SEL_Q, SEL_N, 1'b1, 1'b1);
                    4'd10: u = mk(SEL_N, SEL_P, SEL_M, SEL_Q, 1'b1, 1'b1);
                    4'd11: u = mk(SEL_P, SEL_N, SEL_Q, SEL_M, 1'b1, 1'b1);
                    4'd12: u = mk(SEL_M, SEL_Q, SEL_N, SEL_P, 1'b1, 1'b1);
                    4'd13: u = mk(SEL_Q, SEL_M, SEL_P, SEL_N, 1'b1, 1'b1);
                    4'd14: u = mk(SEL_N, SEL_Q, SEL_M, SEL_P, 1'b1, 1'b1);
                    default: u = mk(SEL_Q, SEL_N, SEL_P, SEL_M, 1'b1, 1'b1);
                endcase
            end
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

>>> design/fmia_ctrl.sv
`default_nettype none
module fmia_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire fmia_pkg::stat_t stat,
    output fmia_pkg::cmd_t       cmd
);
    import fmia_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    unique case (stat.kind)
                        REQ_LOAD_D, REQ_LOAD_F: state_next = ST_LOAD;
                        REQ_INT:                state_next = ST_CHECK;
                        default:                state_next = ST_RD;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.do_load = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RD: begin
                cmd.rd_elem = 1'b1;
                state_next  = ST_RDOUT;
            end
            ST_RDOUT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHECK: begin
                cmd.chk    = 1'b1;
                state_next = stat.int_ok ? ST_FETCH : ST_IDLE;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul     = 1'b1;
                cmd.mul_idx = 2'd0;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul     = 1'b1;
                cmd.mul_idx = 2'd1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul     = 1'b1;
                cmd.mul_idx = 2'd2;
                state_next  = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul     = 1'b1;
                cmd.mul_idx = 2'd3;
                state_next  = ST_RND;
            end
            ST_RND: begin
                cmd.rnd    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = stat.last_step ? ST_IDLE : ST_FETCH;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> design/fmia_dpath.sv
`default_nettype none
module fmia_dpath #(
    parameter int NBASIS = fmia_pkg::NBASIS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire fmia_pkg::cmd_t                cmd,
    output fmia_pkg::stat_t                    stat,
    input  wire logic [1:0]                    s_tuser,
    input  wire logic [fmia_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [fmia_pkg::THR_W-1:0]    cfg_wdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fmia_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser
);
    import fmia_pkg::*;

    localparam int DEPTH = NBASIS * NBASIS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [VAL_W-1:0] MAXV = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] MINV = {1'b1, {(VAL_W-1){1'b0}}};

    logic [VAL_W-1:0] dmem [DEPTH];
    logic [VAL_W-1:0] fmem [DEPTH];

    req_kind_t        kind_reg;
    logic [IDX_W-1:0] row_reg, col_reg, m_reg, n_reg, p_reg, q_reg;
    logic [VAL_W-1:0] lval_reg, ival_reg, imag_reg;
    logic [THR_W-1:0] thr_reg;
    icase_t           case_reg;
    logic [3:0]       step_reg;
    logic             ovf_reg;
    logic [VAL_W-1:0] d_q, f_q, term_reg;
    logic [PROD_W-1:0] prod_reg;
    logic             out_valid_reg, out_flag_reg;
    logic [VAL_W-1:0] out_val_reg;

    function automatic logic [AW-1:0] addr_of(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        logic [2*IDX_W-1:0] a;
        a = {{IDX_W{1'b0}}, r} * (2*IDX_W)'(NBASIS) + {{IDX_W{1'b0}}, c};
        return a[AW-1:0];
    endfunction

    function automatic logic in_rng(logic [IDX_W-1:0] v);
        return {1'b0, v} < (IDX_W+1)'(NBASIS);
    endfunction

    function automatic logic [VAL_W-1:0] mag(logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

    upd_t             u;
    logic [IDX_W-1:0] fr, fc, dr, dc;
    logic             rc_ok, int_ok;
    icase_t           icase;

    function automatic logic [IDX_W-1:0] pick(sel_t s, logic [IDX_W-1:0] a,
                                              logic [IDX_W-1:0] b, logic [IDX_W-1:0] c,
                                              logic [IDX_W-1:0] d);
        logic [IDX_W-1:0] r;
        unique case (s)
            SEL_M:   r = a;
            SEL_N:   r = b;
            SEL_P:   r = c;
            default: r = d;
        endcase
        return r;
    endfunction

    always_comb begin
        u  = upd_lookup(case_reg, step_reg);
        fr = pick(u.fr, m_reg, n_reg, p_reg, q_reg);
        fc = pick(u.fc, m_reg, n_reg, p_reg, q_reg);
        dr = pick(u.dr, m_reg, n_reg, p_reg, q_reg);
        dc = pick(u.dc, m_reg, n_reg, p_reg, q_reg);
        rc_ok  = in_rng(row_reg) && in_rng(col_reg);
        int_ok = in_rng(m_reg) && in_rng(n_reg) && in_rng(p_reg) && in_rng(q_reg)
                 && (imag_reg >= {1'b0, thr_reg});
        priority if (m_reg == n_reg && m_reg == p_reg && m_reg == q_reg) icase = IC_ALL;
        else if (n_reg == m_reg && p_reg == q_reg) icase = IC_MMPP;
        else if (m_reg == p_reg && n_reg == q_reg) icase = IC_MNMN;
        else if (n_reg == m_reg) icase = IC_MM;
        else if (p_reg == q_reg) icase = IC_PP;
        else icase = IC_GEN;
        stat.kind      = req_kind_t'(s_tuser);
        stat.int_ok    = int_ok;
        stat.last_step = (step_reg == last_of(case_reg));
        stat.out_busy  = out_valid_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            kind_reg <= req_kind_t'(s_tuser);
            row_reg  <= s_tdata[7:0];
            col_reg  <= s_tdata[15:8];
            lval_reg <= s_tdata[63:16];
            m_reg    <= s_tdata[71:64];
            n_reg    <= s_tdata[79:72];
            p_reg    <= s_tdata[87:80];
            q_reg    <= s_tdata[95:88];
            ival_reg <= s_tdata[143:96];
            imag_reg <= mag(s_tdata[143:96]);
        end
        if (cmd.chk) begin
            case_reg <= icase;
        end
    end

    // store access
    always_ff @(posedge aclk) begin
        if (cmd.do_load && rc_ok && kind_reg == REQ_LOAD_D) begin
            dmem[addr_of(row_reg, col_reg)] <= lval_reg;
        end
        if (cmd.fetch) begin
            d_q <= dmem[addr_of(dr, dc)];
        end
    end

    logic [VAL_W-1:0] f_new;
    logic             acc_sat;
    logic [VAL_W:0]   sum;

    always_comb begin
        sum = u.sub ? ({f_q[VAL_W-1], f_q} - {term_reg[VAL_W-1], term_reg})
                    : ({f_q[VAL_W-1], f_q} + {term_reg[VAL_W-1], term_reg});
        acc_sat = sum[VAL_W] != sum[VAL_W-1];
        f_new   = acc_sat ? (sum[VAL_W] ? MINV : MAXV) : sum[VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_load && rc_ok && kind_reg == REQ_LOAD_F) begin
            fmem[addr_of(row_reg, col_reg)] <= lval_reg;
        end else if (cmd.acc) begin
            fmem[addr_of(fr, fc)] <= f_new;
        end
        if (cmd.rd_elem) begin
            f_q <= fmem[addr_of(row_reg, col_reg)];
        end else if (cmd.fetch) begin
            f_q <= fmem[addr_of(fr, fc)];
        end
    end

    // serial 24x24 product of magnitudes
    logic [VAL_W-1:0]  dmag;
    logic [PP_W-1:0]   pa, pb;
    logic [2*PP_W-1:0] pp;
    logic [PROD_W-1:0] pp_sh;

    always_comb begin
        dmag = mag(d_q);
        unique case (cmd.mul_idx)
            2'd0: begin
                pa = dmag[PP_W-1:0]; pb = imag_reg[PP_W-1:0];
            end
            2'd1: begin
                pa = dmag[PP_W-1:0]; pb = imag_reg[VAL_W-1:PP_W];
            end
            2'd2: begin
                pa = dmag[VAL_W-1:PP_W]; pb = imag_reg[PP_W-1:0];
            end
            default: begin
                pa = dmag[VAL_W-1:PP_W]; pb = imag_reg[VAL_W-1:PP_W];
            end
        endcase
        pp = pa * pb;
        unique case (cmd.mul_idx)
            2'd0:       pp_sh = {{(PROD_W-2*PP_W){1'b0}}, pp};
            2'd1, 2'd2: pp_sh = {{(PROD_W-2*PP_W){1'b0}}, pp} << PP_W;
            default:    pp_sh = {{(PROD_W-2*PP_W){1'b0}}, pp} << (2*PP_W);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= (cmd.mul_idx == 2'd0) ? pp_sh : (prod_reg + pp_sh);
        end
    end

    // round half away from zero, saturate
    logic [PROD_W-1:0] rnd;
    logic [63:0]       r;
    logic              neg, term_sat;
    logic [VAL_W-1:0]  term_next;

    always_comb begin
        rnd = prod_reg + (u.half ? (PROD_W'(1) << 32) : (PROD_W'(1) << 31));
        r   = u.half ? rnd[96-1:33] : rnd[95:32];
        neg = d_q[VAL_W-1] ^ ival_reg[VAL_W-1];
        if (neg) begin
            term_sat  = r > 64'h8000_0000_0000;
            term_next = term_sat ? MINV : (~r[VAL_W-1:0] + 1'b1);
        end else begin
            term_sat  = r > 64'h7FFF_FFFF_FFFF;
            term_next = term_sat ? MAXV : r[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rnd) begin
            term_reg <= term_next;
        end
        if (cmd.load_out) begin
            out_val_reg  <= rc_ok ? f_q : '0;
            out_flag_reg <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= '0;
            ovf_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if ((cmd.rnd && term_sat) || (cmd.acc && acc_sat)) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.chk) begin
                step_reg <= '0;
            end else if (cmd.acc) begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_flag_reg;

endmodule
`default_nettype wire

>>> design/fock_matrix_integral_accumulate.sv
// Fock matrix builder over unique two-electron integrals (RHF, eightfold symmetry),
// Q15.32 fixed point with saturation and a sticky overflow flag. Requests are taken
// one at a time: an integral makes 1, 4, 6, 8 or 16 Fock updates by index
// coincidence, each a fetch, four multiply steps, a round and an accumulate; the
// update loop is bound by the single read-modify-write port of the Fock store and
// a 24x24 multiplier used four times per term.
`default_nettype none
module fock_matrix_integral_accumulate #(
    parameter int NBASIS = fmia_pkg::NBASIS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // row, col, load_value, idx_m, idx_n, idx_p, idx_q, integral_value
    input  wire logic [fmia_pkg::S_DATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_value
    output logic [fmia_pkg::M_DATA_W-1:0]      m_tdata,
    // overflow_seen
    output logic                               m_tuser,
    input  wire logic                          cfg_we,
    input  wire logic [fmia_pkg::THR_W-1:0]    cfg_wdata
);
    import fmia_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fmia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmia_dpath #(.NBASIS(NBASIS)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

>>> design/fmia_chk.sv
`default_nettype none
module fmia_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);
    logic seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tuser) begin
            seen_reg <= 1'b1;
        end
    end

    a_rst_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_reg |-> m_tuser)
        else $error("overflow flag cleared");

endmodule

bind fock_matrix_integral_accumulate fmia_chk u_fmia_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/sv/fock_matrix_integral_accumulate_tb.sv
`default_nettype none
module fock_matrix_integral_accumulate_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fmia_pkg::*;

    localparam int  NB        = NBASIS_DEF;
    localparam int  MAX_MISS  = 10;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF;
    localparam logic signed [63:0] VMIN = -64'sh8000_0000_0000;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             ovf;
    } fock_read_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_we = 1'b0;
    logic [THR_W-1:0]    cfg_wdata = '0;

    // predictor state
    logic signed [63:0] dens_model [NB*NB];
    logic signed [63:0] fock_model [NB*NB];
    bit                 dens_written [NB*NB];
    bit                 fock_written [NB*NB];
    bit                 ovf_model;
    logic [THR_W-1:0]   thr_model;

    fock_read_t fock_reads_due[$];
    int         mismatches = 0;
    longint     cycles = 0;
    int         results_seen = 0;
    bit         hold_off = 1'b0;

    fock_matrix_integral_accumulate i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [63:0] sat_value(logic signed [63:0] v);
        if (v > VMAX) begin
            ovf_model = 1'b1;
            return VMAX;
        end
        if (v < VMIN) begin
            ovf_model = 1'b1;
            return VMIN;
        end
        return v;
    endfunction

    // round(d*i / 2^s), ties away from zero, saturated
    function automatic logic signed [63:0] scaled_product(logic signed [63:0] d,
                                                          logic signed [63:0] i, int s);
        logic [127:0] a, b, p, r;
        bit           neg;
        neg = (d < 0) != (i < 0);
        a = (d < 0) ? 128'(-d) : 128'(d);
        b = (i < 0) ? 128'(-i) : 128'(i);
        p = a * b;
        r = (p + (128'd1 << (s - 1))) >> s;
        if (neg) begin
            if (r > 128'h8000_0000_0000) begin
                ovf_model = 1'b1;
                return VMIN;
            end
            return -$signed(64'(r));
        end
        if (r > 128'h7FFF_FFFF_FFFF) begin
            ovf_model = 1'b1;
            return VMAX;
        end
        return $signed(64'(r));
    endfunction

    task automatic fock_update(int fr, int fc, int dr, int dc, logic signed [63:0] v,
                               bit half, bit sub);
        logic signed [63:0] t;
        int                 k;
        k = fr * NB + fc;
        t = scaled_product(dens_model[dr*NB+dc], v, half ? 33 : 32);
        fock_model[k] = sat_value(sub ? fock_model[k] - t : fock_model[k] + t);
    endtask

    task automatic apply_integral(int m, int n, int p, int q, logic signed [63:0] v);
        if (m == n && m == p && m == q) begin
            fock_update(m, m, m, m, v, 1, 0);
        end else if (n == m && p == q) begin
            fock_update(m, m, p, p, v, 0, 0);
            fock_update(p, p, m, m, v, 0, 0);
            fock_update(m, p, m, p, v, 1, 1);
            fock_update(p, m, p, m, v, 1, 1);
        end else if (m == p && n == q) begin
            fock_update(m, n, m, n, v, 0, 0);
            fock_update(m, n, n, m, v, 1, 0);
            fock_update(n, m, n, m, v, 0, 0);
            fock_update(n, m, m, n, v, 1, 0);
            fock_update(n, n, m, m, v, 1, 1);
            fock_update(m, m, n, n, v, 1, 1);
        end else if (n == m) begin
            fock_update(m, m, p, q, v, 0, 0);
            fock_update(m, m, q, p, v, 0, 0);
            fock_update(p, q, m, m, v, 0, 0);
            fock_update(q, p, m, m, v, 0, 0);
            fock_update(m, p, m, q, v, 1, 1);
            fock_update(p, m, q, m, v, 1, 1);
            fock_update(m, q, m, p, v, 1, 1);
            fock_update(q, m, p, m, v, 1, 1);
        end else if (p == q) begin
            fock_update(m, n, p, p, v, 0, 0);
            fock_update(n, m, p, p, v, 0, 0);
            fock_update(p, p, m, n, v, 0, 0);
            fock_update(p, p, n, m, v, 0, 0);
            fock_update(m, p, n, p, v, 1, 1);
            fock_update(p, m, p, n, v, 1, 1);
            fock_update(n, p, m, p, v, 1, 1);
            fock_update(p, n, p, m, v, 1, 1);
        end else begin
            fock_update(m, n, p, q, v, 0, 0);
            fock_update(n, m, p, q, v, 0, 0);
            fock_update(m, n, q, p, v, 0, 0);
            fock_update(n, m, q, p, v, 0, 0);
            fock_update(p, q, m, n, v, 0, 0);
            fock_update(p, q, n, m, v, 0, 0);
            fock_update(q, p, m, n, v, 0, 0);
            fock_update(q, p, n, m, v, 0, 0);
            fock_update(m, p, n, q, v, 1, 1);
            fock_update(p, m, q, n, v, 1, 1);
            fock_update(n, p, m, q, v, 1, 1);
            fock_update(p, n, q, m, v, 1, 1);
            fock_update(m, q, n, p, v, 1, 1);
            fock_update(q, m, p, n, v, 1, 1);
            fock_update(n, q, m, p, v, 1, 1);
            fock_update(q, n, p, m, v, 1, 1);
        end
    endtask

    // whether every store entry an integral touches has been written
    function automatic bit integral_covered(int m, int n, int p, int q);
        int ix[4];
        ix = '{m, n, p, q};
        foreach (ix[a]) foreach (ix[b]) begin
            if (!dens_written[ix[a]*NB+ix[b]] || !fock_written[ix[a]*NB+ix[b]])
                return 0;
        end
        return 1;
    endfunction

    task automatic predict_request(req_kind_t kind, int row, int col,
                                   logic [VAL_W-1:0] lv, int m, int n, int p, int q,
                                   logic [VAL_W-1:0] iv);
        bit                 inr;
        logic signed [63:0] v;
        logic [63:0]        mg;
        fock_read_t         r;
        inr = row < NB && col < NB;
        case (kind)
            REQ_LOAD_D: if (inr) begin
                dens_model[row*NB+col] = 64'($signed(lv));
                dens_written[row*NB+col] = 1;
            end
            REQ_LOAD_F: if (inr) begin
                fock_model[row*NB+col] = 64'($signed(lv));
                fock_written[row*NB+col] = 1;
            end
            REQ_INT: begin
                v = 64'($signed(iv));
                mg = (v < 0) ? 64'(-v) : 64'(v);
                if (m < NB && n < NB && p < NB && q < NB && mg >= 64'(thr_model))
                    apply_integral(m, n, p, q, v);
            end
            default: begin
                r.value = inr ? fock_model[row*NB+col][VAL_W-1:0] : '0;
                r.ovf = ovf_model;
                fock_reads_due.push_back(r);
            end
        endcase
    endtask

    task automatic send_request(req_kind_t kind, int row, int col, logic [VAL_W-1:0] lv,
                                int m, int n, int p, int q, logic [VAL_W-1:0] iv,
                                bit gaps = 1);
        int w;
        w = gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
            s_tvalid <= 1'b0;
            repeat (w) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {iv, q[7:0], p[7:0], n[7:0], m[7:0], lv, col[7:0], row[7:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(kind, row, col, lv, m, n, p, q, iv);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        fock_read_t e;
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (fock_reads_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_MISS)
                    $display("unexpected result %h ovf %b", m_tdata, m_tuser);
            end else begin
                e = fock_reads_due.pop_front();
                if (e.value !== m_tdata || e.ovf !== m_tuser) begin
                    mismatches++;
                    if (mismatches <= MAX_MISS)
                        $display("read mismatch: exp %h/%b got %h/%b",
                                 e.value, e.ovf, m_tdata, m_tuser);
                end
            end
        end
    end

    initial begin
        int w;
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                @(negedge aclk);
            end else begin
                w = $urandom_range(0, 15);
                if ($urandom_range(0, 2) == 0) w = 0;
                if (w > 0) begin
                    m_tready <= 1'b0;
                    repeat (w) @(negedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
                while (!m_tvalid) @(posedge aclk);
                @(negedge aclk);
            end
        end
    end

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        while (fock_reads_due.size() != 0) @(negedge aclk);
        repeat (130) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] t);
        drain_and_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= t;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        thr_model = t;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 32'($urandom)};
            3: return {$urandom_range(0, 1) ? 12'hFFF : 12'h000, 36'({$urandom, $urandom})};
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    task automatic load_block(int b0, int sz);
        for (int r = b0; r < b0 + sz; r++)
            for (int c = b0; c < b0 + sz; c++) begin
                send_request(REQ_LOAD_D, r, c, rand_value(), 0, 0, 0, 0, '0);
                send_request(REQ_LOAD_F, r, c, rand_value(), 0, 0, 0, 0, '0);
            end
    endtask

    task automatic test_directed();
        load_block(0, 4);
        send_request(REQ_LOAD_D, 63, 63, 48'h0001_0000_0000, 0, 0, 0, 0, '0);
        send_request(REQ_LOAD_F, 63, 63, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, '0);
        send_request(REQ_LOAD_D, 64, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, '0);
        send_request(REQ_LOAD_F, 0, 255, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, '0);
        send_request(REQ_INT, 0, 0, '0, 1, 1, 1, 1, 48'h0000_8000_0000);
        send_request(REQ_INT, 0, 0, '0, 0, 0, 2, 2, 48'hFFFF_0000_0001);
        send_request(REQ_INT, 0, 0, '0, 1, 3, 1, 3, 48'h0000_0000_0001);
        send_request(REQ_INT, 0, 0, '0, 2, 2, 0, 3, 48'h0003_0000_0000);
        send_request(REQ_INT, 0, 0, '0, 0, 1, 3, 3, 48'hFFFF_FFFF_FFFF);
        send_request(REQ_INT, 0, 0, '0, 0, 1, 2, 3, 48'h0010_0000_0000);
        send_request(REQ_INT, 0, 0, '0, 0, 1, 2, 64, 48'h0010_0000_0000);
        send_request(REQ_INT, 0, 0, '0, 255, 1, 2, 3, 48'h0010_0000_0000);
        send_request(REQ_INT, 0, 0, '0, 63, 63, 63, 63, 48'h7FFF_FFFF_FFFF);
        send_request(REQ_INT, 0, 0, '0, 1, 1, 1, 1, 48'h8000_0000_0000);
        send_request(REQ_INT, 0, 0, '0, 0, 1, 2, 3, 48'h8000_0000_0000);
        for (int r = 0; r < 4; r++)
            send_request(REQ_READ, r, r, '0, 0, 0, 0, 0, '0);
        send_request(REQ_READ, 63, 63, '0, 0, 0, 0, 0, '0);
        send_request(REQ_READ, 255, 0, '0, 0, 0, 0, 0, '0);
        send_request(REQ_READ, 0, 64, '0, 0, 0, 0, 0, '0);
    endtask

    task automatic random_phase(int count, int b0, int sz);
        int                k, m, n, p, q, r, c;
        logic [VAL_W-1:0]  iv;
        for (int it = 0; it < count; it++) begin
            k = $urandom_range(0, 9);
            r = b0 + $urandom_range(0, sz - 1);
            c = b0 + $urandom_range(0, sz - 1);
            if (k < 5) begin
                m = b0 + $urandom_range(0, sz - 1);
                n = $urandom_range(0, 2) == 0 ? m : b0 + $urandom_range(0, sz - 1);
                p = b0 + $urandom_range(0, sz - 1);
                q = $urandom_range(0, 2) == 0 ? p : b0 + $urandom_range(0, sz - 1);
                if ($urandom_range(0, 4) == 0) begin
                    p = m;
                    q = n;
                end
                if ($urandom_range(0, 15) == 0) q = $urandom_range(64, 255);
                iv = rand_value();
                if (q >= NB || integral_covered(m, n, p, q)) begin
                    send_request(REQ_INT, 0, 0, 48'({$urandom, $urandom}), m, n, p, q, iv);
                end else begin
                    s_tvalid <= 1'b0;
                    @(negedge aclk);
                end
            end else if (k < 7) begin
                send_request(REQ_READ, r, c, 48'({$urandom, $urandom}), 0, 0, 0, 0, '0);
            end else if (k == 7) begin
                send_request(REQ_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                             '0, 0, 0, 0, 0, '0);
            end else if (k == 8) begin
                send_request(REQ_LOAD_D, r, c, rand_value(), 0, 0, 0, 0, '0);
            end else begin
                if ($urandom_range(0, 5) == 0) begin
                    r = $urandom_range(0, 255);
                    c = $urandom_range(0, 255);
                end
                send_request(REQ_LOAD_F, r, c, rand_value(), 0, 0, 0, 0, '0);
            end
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_request(REQ_READ, i % 4, 0, '0, 0, 0, 0, 0, '0, 0);
        join
    endtask

    task automatic test_thresholds();
        logic [THR_W-1:0] t;
        t = 47'h0000_8000_0000;
        write_threshold(t);
        random_phase(250, 0, 4);
        write_threshold(47'h7FFF_FFFF_FFFF);
        random_phase(120, 0, 4);
        write_threshold(47'd0);
    endtask

    initial begin
        thr_model = '0;
        ovf_model = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        load_block(8, 3);
        random_phase(500, 8, 3);
        test_thresholds();
        load_block(60, 4);
        random_phase(560, 60, 4);
        drain_and_idle();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
design/fmia_pkg.sv
design/fmia_ctrl.sv
design/fmia_dpath.sv
design/fock_matrix_integral_accumulate.sv
design/fmia_chk.sv
tb/sv/fock_matrix_integral_accumulate_tb.sv
